// File: src/guarded_float_divide_instruction_core_assert.svh
// Assertion macros for the guarded float divide core checker
`ifndef GUARDED_FLOAT_DIVIDE_INSTRUCTION_CORE_ASSERT_SVH
`define GUARDED_FLOAT_DIVIDE_INSTRUCTION_CORE_ASSERT_SVH
// check an implication on every clock edge outside reset
`define GFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// check a consequence in the cycle after the antecedent
`define GFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/gfd_pkg.sv
// Shared types and constants of the guarded float divide core
package gfd_pkg;
  localparam int MEM_WORDS   = 1024;
  localparam int SUBPROGRAMS = 256;
  localparam int AddrW       = $clog2(MEM_WORDS);
  localparam int SpW         = $clog2(SUBPROGRAMS);

  localparam logic [1:0] ModeLoad   = 2'd0;
  localparam logic [1:0] ModeDivide = 2'd1;
  localparam logic [1:0] ModeRead   = 2'd2;

  localparam logic KindRead   = 1'b0;
  localparam logic KindDivide = 1'b1;

  localparam logic [31:0] BitsOne  = 32'h3F80_0000;
  localparam logic [30:0] BitsFmax = 31'h7F7F_FFFF;
  localparam logic [31:0] BitsQnan = 32'h7FC0_0000;

  localparam int QuotBits = 25;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_RDW, ST_START, ST_WAITD, ST_FIN
  } core_state_e;

  typedef enum logic [2:0] {
    D_IDLE, D_NORM, D_ALIGN, D_DIV, D_DENORM, D_ROUND, D_DONE
  } div_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;
endpackage

// File: src/gfd_div.sv
// Bit-serial guarded single-precision divider with round to nearest even
module gfd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gfd_pkg::div_req_t req_i,
  output gfd_pkg::div_rsp_t rsp_o
);
  import gfd_pkg::*;

  div_state_e state_q, state_d;

  logic [23:0]         ma_q, mb_q;
  logic signed [10:0]  ea_q, eb_q, e_q;
  logic [QuotBits-1:0] rem_q, qt_q;
  logic                stk_q, sign_q, spec_q;
  logic [4:0]          cnt_q;
  logic [31:0]         res_q;

  logic [7:0]  fa_exp, fb_exp;
  logic [22:0] fa_frac, fb_frac;
  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan, q_sign;
  logic [31:0] spec_res;
  logic        is_spec;

  assign fa_exp  = req_i.op_a[30:23];
  assign fb_exp  = req_i.op_b[30:23];
  assign fa_frac = req_i.op_a[22:0];
  assign fb_frac = req_i.op_b[22:0];
  assign a_zero  = (req_i.op_a[30:0] == 31'd0);
  assign b_zero  = (req_i.op_b[30:0] == 31'd0);
  assign a_inf   = (fa_exp == 8'hFF) && (fa_frac == 23'd0);
  assign b_inf   = (fb_exp == 8'hFF) && (fb_frac == 23'd0);
  assign a_nan   = (fa_exp == 8'hFF) && (fa_frac != 23'd0);
  assign b_nan   = (fb_exp == 8'hFF) && (fb_frac != 23'd0);
  assign q_sign  = req_i.op_a[31] ^ req_i.op_b[31];

  always_comb begin
    is_spec  = 1'b1;
    spec_res = 32'd0;
    if (b_zero) begin
      if (a_zero) begin
        spec_res = BitsOne;
      end else if (!a_nan && !req_i.op_a[31]) begin
        spec_res = {1'b0, BitsFmax};
      end else begin
        spec_res = {1'b1, BitsFmax};
      end
    end else if (a_nan || b_nan || (a_inf && b_inf)) begin
      spec_res = BitsQnan;
    end else if (a_inf) begin
      spec_res = {q_sign, BitsFmax};
    end else if (b_inf || a_zero) begin
      spec_res = {q_sign, 31'd0};
    end else begin
      is_spec = 1'b0;
    end
  end

  // rounding of the finished quotient
  logic [23:0] mant;
  logic        inc;
  logic [24:0] mant_r;
  logic [9:0]  field;
  logic [32:0] packed_sum;
  logic [31:0] round_res;

  assign mant       = qt_q[QuotBits-1:1];
  assign inc        = qt_q[0] & (stk_q | mant[0]);
  assign mant_r     = {1'b0, mant} + {24'd0, inc};
  assign field      = 10'(e_q - 11'sd1);
  assign packed_sum = {field, 23'd0} + {8'd0, mant_r};
  assign round_res  = (packed_sum >= 33'h0_7F80_0000) ? {sign_q, BitsFmax}
                                                      : {sign_q, packed_sum[30:0]};

  // one restoring step per cycle
  logic                ge;
  logic [QuotBits-1:0] rem_sub;
  assign ge      = (rem_q >= {1'b0, mb_q});
  assign rem_sub = ge ? (rem_q - {1'b0, mb_q}) : rem_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      D_IDLE:   if (req_i.start) state_d = is_spec ? D_DONE : D_NORM;
      D_NORM:   if (ma_q[23] && mb_q[23]) state_d = D_ALIGN;
      D_ALIGN:  state_d = D_DIV;
      D_DIV:    if (cnt_q == 5'd1) state_d = D_DENORM;
      D_DENORM: if (e_q >= 11'sd1) state_d = D_ROUND;
      D_ROUND:  state_d = D_DONE;
      D_DONE:   state_d = D_IDLE;
      default:  state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        spec_q <= is_spec;
        res_q  <= spec_res;
        sign_q <= q_sign;
        ma_q   <= {(fa_exp != 8'd0), fa_frac};
        mb_q   <= {(fb_exp != 8'd0), fb_frac};
        ea_q   <= (fa_exp == 8'd0) ? 11'sd1 : $signed({3'd0, fa_exp});
        eb_q   <= (fb_exp == 8'd0) ? 11'sd1 : $signed({3'd0, fb_exp});
      end
      D_NORM: begin
        // shift subnormal mantissas up one bit a cycle
        if (!ma_q[23]) begin
          ma_q <= {ma_q[22:0], 1'b0};
          ea_q <= ea_q - 11'sd1;
        end
        if (!mb_q[23]) begin
          mb_q <= {mb_q[22:0], 1'b0};
          eb_q <= eb_q - 11'sd1;
        end
      end
      D_ALIGN: begin
        cnt_q <= 5'(QuotBits);
        qt_q  <= '0;
        stk_q <= 1'b0;
        if (ma_q < mb_q) begin
          rem_q <= {ma_q, 1'b0};
          e_q   <= ea_q - eb_q + 11'sd126;
        end else begin
          rem_q <= {1'b0, ma_q};
          e_q   <= ea_q - eb_q + 11'sd127;
        end
      end
      D_DIV: begin
        qt_q  <= {qt_q[QuotBits-2:0], ge};
        rem_q <= {rem_sub[QuotBits-2:0], 1'b0};
        cnt_q <= cnt_q - 5'd1;
      end
      D_DENORM: begin
        if (cnt_q == 5'd0) begin
          stk_q <= stk_q | (rem_q != '0);
          cnt_q <= 5'd1;
        end
        if (e_q < 11'sd1) begin
          if (e_q < -11'sd26) begin
            // everything falls below the round bit
            qt_q  <= '0;
            stk_q <= 1'b1;
            e_q   <= 11'sd1;
          end else begin
            qt_q  <= {1'b0, qt_q[QuotBits-1:1]};
            stk_q <= stk_q | qt_q[0] | (rem_q != '0);
            e_q   <= e_q + 11'sd1;
          end
        end
      end
      D_ROUND: begin
        if (!spec_q) res_q <= round_res;
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = (state_q == D_DONE);
  assign rsp_o.result = res_q;
endmodule

// File: src/guarded_float_divide_instruction_core.sv
// Load writes memory on accept. Read goes via ST_RDA and ST_RDW to the output register.
// Divide skips quotient steps for a zero divisor or special operand, else runs 25 of them
// plus serial normalization of subnormals and serial denormalization of tiny results.
// Throughput: one instruction at a time, the next is taken once the result is registered.
// Reset: control and instruction pointers clear at once; data memory is undefined until
// written.
module guarded_float_divide_instruction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // src_a_addr[9:0], src_b_addr[19:10], dest_addr[29:20], load_word[61:30],
  // subprogram[69:62], zero[71:70]
  input  logic [71:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // word_out[31:0], written_addr[41:32], next_ip[57:42], zero[63:58]
  output logic [63:0] m_axis_tdata,
  // kind[0]
  output logic        m_axis_tuser
);
  import gfd_pkg::*;

  core_state_e state_q, state_d;

  logic [31:0] data_mem [MEM_WORDS];
  logic [15:0] ip_mem   [SUBPROGRAMS];
  logic [SUBPROGRAMS-1:0] ip_vld_q;

  logic [1:0]       mode_q;
  logic [AddrW-1:0] a_q, b_q, d_q;
  logic [SpW-1:0]   sp_q;
  logic [31:0]      rd_data_q, opa_q;
  logic [15:0]      ip_rd_q;
  logic             ip_rd_vld_q;

  logic        res_kind_q;
  logic [31:0] res_word_q;
  logic [AddrW-1:0] res_addr_q;
  logic [15:0] res_ip_q;

  logic        out_valid_q, out_kind_q;
  logic [63:0] out_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             accept;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata;
  logic [15:0]      ip_next;
  logic             fin_go;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ip_next       = (ip_rd_vld_q ? ip_rd_q : 16'd0) + 16'd1;
  assign fin_go        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  gfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_req.start = (state_q == ST_START);
  assign div_req.op_a  = opa_q;
  assign div_req.op_b  = rd_data_q;

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = d_q;
    mem_wdata = div_rsp.result;
    mem_raddr = a_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == ModeLoad) begin
            mem_we    = 1'b1;
            mem_waddr = s_axis_tdata[AddrW-1:0];
            mem_wdata = s_axis_tdata[61:30];
          end else if (s_axis_tuser == ModeDivide || s_axis_tuser == ModeRead) begin
            state_d = ST_RDA;
          end
        end
      end
      ST_RDA:   state_d = (mode_q == ModeRead) ? ST_RDW : ST_RDB;
      ST_RDB: begin
        mem_raddr = b_q;
        state_d   = ST_START;
      end
      ST_RDW:   state_d = ST_FIN;
      ST_START: state_d = ST_WAITD;
      ST_WAITD: begin
        if (div_rsp.done) begin
          mem_we  = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ip_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_WAITD && div_rsp.done) ip_vld_q[sp_q] <= 1'b1;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) data_mem[mem_waddr] <= mem_wdata;
    rd_data_q <= data_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAITD && div_rsp.done) ip_mem[sp_q] <= ip_next;
    ip_rd_q     <= ip_mem[sp_q];
    ip_rd_vld_q <= ip_vld_q[sp_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tuser;
      a_q    <= s_axis_tdata[AddrW-1:0];
      b_q    <= s_axis_tdata[10+AddrW-1:10];
      d_q    <= s_axis_tdata[20+AddrW-1:20];
      sp_q   <= s_axis_tdata[62+SpW-1:62];
    end
    if (state_q == ST_RDB) opa_q <= rd_data_q;
    if (state_q == ST_RDW) begin
      res_kind_q <= KindRead;
      res_word_q <= rd_data_q;
      res_addr_q <= a_q;
      res_ip_q   <= 16'd0;
    end
    if (state_q == ST_WAITD && div_rsp.done) begin
      res_kind_q <= KindDivide;
      res_word_q <= div_rsp.result;
      res_addr_q <= d_q;
      res_ip_q   <= ip_next;
    end
    if (fin_go) begin
      out_kind_q <= res_kind_q;
      out_data_q <= {6'd0, res_ip_q, 10'(res_addr_q), res_word_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
endmodule

// File: src/gfd_checker.sv
// Port-level checker for the guarded float divide core and its bind
`include "guarded_float_divide_instruction_core_assert.svh"
module gfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  logic out_stall, out_read, out_div;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_read  = m_axis_tvalid && !m_axis_tuser;
  assign out_div   = m_axis_tvalid && m_axis_tuser;

  `GFD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped")
  `GFD_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "stalled result changed")
  `GFD_ASSERT_IMPL(a_read_ip, out_read, m_axis_tdata[57:42] == 16'd0, "read has an ip")
  `GFD_ASSERT_IMPL(a_no_inf, out_div, m_axis_tdata[30:0] != 31'h7F80_0000, "infinite quotient")
  `GFD_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[63:58] == 6'd0, "padding bits set")
endmodule

bind guarded_float_divide_instruction_core gfd_checker u_gfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
